// ===== hw/rtl/lrub_pkg.sv =====
// shared types, constants and the control program for the lru group cache
// no dependencies; imported by every module of the block
package lrub_pkg;

  localparam int GID_W   = 8;
  localparam int BYTES_W = 36;
  localparam int TOTAL_W = 40;
  localparam int STAMP_W = 30;
  localparam int KIND_W  = 2;

  localparam int NUM_GROUPS_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

  localparam logic [STAMP_W-1:0] STAMP_LIMIT  = 30'd1000000000;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};
  localparam logic [TOTAL_W-1:0] BUDGET_RESET = 40'd4294967296;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_HIT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MISS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd3;

  typedef struct packed {
    logic [GID_W-1:0]   group_id;
    logic [BYTES_W-1:0] load_size;
  } in_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [GID_W-1:0]   which_group;
    logic [TOTAL_W-1:0] total_bytes;
    logic               last;
  } out_beat_t;

  // datapath actions
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_RESTAMP,
    ACT_LOAD,
    ACT_SCAN_INIT,
    ACT_SCAN_STEP,
    ACT_EVICT,
    ACT_EMIT_LAST,
    ACT_SET_REJ,
    ACT_SET_HIT
  } act_e;

  // branch conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_BAD_ID,
    C_HIT,
    C_NO_EVICT,
    C_SCAN_MORE,
    C_NOT_FOUND
  } cond_e;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] ST_CHECK  = 4'd1;
  localparam logic [PC_W-1:0] ST_STAMP  = 4'd2;
  localparam logic [PC_W-1:0] ST_LOAD   = 4'd3;
  localparam logic [PC_W-1:0] ST_BUDGET = 4'd4;
  localparam logic [PC_W-1:0] ST_SCAN   = 4'd5;
  localparam logic [PC_W-1:0] ST_DRAIN  = 4'd6;
  localparam logic [PC_W-1:0] ST_PICK   = 4'd7;
  localparam logic [PC_W-1:0] ST_EVICT  = 4'd8;
  localparam logic [PC_W-1:0] ST_FINAL  = 4'd9;
  localparam logic [PC_W-1:0] ST_REJECT = 4'd10;
  localparam logic [PC_W-1:0] ST_HIT    = 4'd11;

  typedef struct packed {
    logic            wait_in;
    logic            wait_out;
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] tgt;
  } ucode_t;

  typedef struct packed {
    logic fire;
    act_e act;
  } ctrl_t;

  typedef struct packed {
    logic bad_id;
    logic hit;
    logic no_evict;
    logic scan_more;
    logic found;
  } stat_t;

  // control program, one word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      ST_IDLE:   w = '{wait_in: 1'b1, wait_out: 1'b0, act: ACT_ACCEPT,
                       cond: C_NONE, tgt: ST_IDLE};
      ST_CHECK:  w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_NONE,
                       cond: C_BAD_ID, tgt: ST_REJECT};
      ST_STAMP:  w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_RESTAMP,
                       cond: C_HIT, tgt: ST_HIT};
      ST_LOAD:   w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_LOAD,
                       cond: C_NONE, tgt: ST_IDLE};
      ST_BUDGET: w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_SCAN_INIT,
                       cond: C_NO_EVICT, tgt: ST_FINAL};
      ST_SCAN:   w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_SCAN_STEP,
                       cond: C_SCAN_MORE, tgt: ST_SCAN};
      ST_DRAIN:  w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_NONE,
                       cond: C_NONE, tgt: ST_IDLE};
      ST_PICK:   w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_NONE,
                       cond: C_NOT_FOUND, tgt: ST_FINAL};
      ST_EVICT:  w = '{wait_in: 1'b0, wait_out: 1'b1, act: ACT_EVICT,
                       cond: C_ALWAYS, tgt: ST_BUDGET};
      ST_FINAL:  w = '{wait_in: 1'b0, wait_out: 1'b1, act: ACT_EMIT_LAST,
                       cond: C_ALWAYS, tgt: ST_IDLE};
      ST_REJECT: w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_SET_REJ,
                       cond: C_ALWAYS, tgt: ST_FINAL};
      ST_HIT:    w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_SET_HIT,
                       cond: C_ALWAYS, tgt: ST_FINAL};
      default:   w = '{wait_in: 1'b0, wait_out: 1'b0, act: ACT_NONE,
                       cond: C_ALWAYS, tgt: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/lru_group_cache_budget_evict_top.sv =====
// top level of the lru group cache with byte budget eviction
// depends on lrub_pkg, lrub_seq and lrub_dp
//
//  channel | ports                              | beat
//  --------+------------------------------------+------------------------------
//  in      | in_valid, in_ready, in_beat        | group_id, load_size
//  out     | out_valid, out_ready, out_beat     | kind, which_group, total, last
//  cfg     | cfg_valid, cfg_ready, cfg_data     | memory budget in bytes
//
// an access: idle, check, then reject or restamp, then hit or load and budget;
// an eviction adds scan, drain, pick, evict; a vain scan stops at pick; each scan
// reads the stamp and bytes memories through a registered port, one group per cycle
// synchronous active-low reset clears flags, counters and totals; no clearing pass
// a stalled out beat holds the sequencer on its emit step; new input beats
// are taken only on the idle step once the previous access is fully issued
module lru_group_cache_budget_evict_top #(
  parameter int NUM_GROUPS = lrub_pkg::NUM_GROUPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lrub_pkg::in_beat_t           in_beat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lrub_pkg::out_beat_t          out_beat,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lrub_pkg::TOTAL_W-1:0] cfg_data
);
  import lrub_pkg::*;

  ctrl_t     ctrl;
  stat_t     stat;
  out_beat_t pend;

  logic               out_valid_r;
  out_beat_t          out_beat_r;
  out_beat_t          out_beat_nxt;
  logic [TOTAL_W-1:0] budget_r;
  logic               out_free;
  logic               out_load;

  // budget register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (cfg_valid) begin
      budget_r <= cfg_data;
    end
  end

  // output register: a pending result moves here on an emit step
  assign out_free = !out_valid_r || out_ready;
  assign out_load = ctrl.fire && (ctrl.act == ACT_EVICT || ctrl.act == ACT_EMIT_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // the final beat of an access carries last
  always_comb begin
    out_beat_nxt      = pend;
    out_beat_nxt.last = (ctrl.act == ACT_EMIT_LAST);
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  lrub_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  lrub_dp #(
    .NUM_GROUPS (NUM_GROUPS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .in_beat (in_beat),
    .budget  (budget_r),
    .stat    (stat),
    .pend    (pend)
  );

endmodule

// ===== hw/rtl/lrub_seq.sv =====
// microcode sequencer: step counter, program rom lookup and branch logic
// depends on lrub_pkg
module lrub_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_free,
  input  lrub_pkg::stat_t stat,
  output logic            in_ready,
  output lrub_pkg::ctrl_t ctrl
);
  import lrub_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          word;
  logic            fire;
  logic            take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    word = ucode_rom(pc_r);
    fire = (!word.wait_in || in_valid) && (!word.wait_out || out_free);
    case (word.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_BAD_ID:    take = stat.bad_id;
      C_HIT:       take = stat.hit;
      C_NO_EVICT:  take = stat.no_evict;
      C_SCAN_MORE: take = stat.scan_more;
      C_NOT_FOUND: take = !stat.found;
      default:     take = 1'b0;
    endcase
    if (!fire) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = word.tgt;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
    in_ready  = word.wait_in;
    ctrl.fire = fire;
    ctrl.act  = word.act;
  end

endmodule

// ===== hw/rtl/lrub_dp.sv =====
// datapath: per-group entry store, stamp counter, resident total, lru scan
// depends on lrub_pkg; driven by the control word of lrub_seq
module lrub_dp #(
  parameter int NUM_GROUPS = lrub_pkg::NUM_GROUPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lrub_pkg::ctrl_t              ctrl,
  input  lrub_pkg::in_beat_t           in_beat,
  input  logic [lrub_pkg::TOTAL_W-1:0] budget,
  output lrub_pkg::stat_t              stat,
  output lrub_pkg::out_beat_t          pend
);
  import lrub_pkg::*;

  localparam int IDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  // entry store: stamps and bytes in memory, flags in flops
  logic [STAMP_W-1:0] stamp_mem [NUM_GROUPS];
  logic [BYTES_W-1:0] bytes_mem [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] resident_r;
  logic [NUM_GROUPS-1:0] svld_r;

  logic [GID_W-1:0]   gid_r;
  logic [BYTES_W-1:0] size_r;
  logic [STAMP_W-1:0] stamp_cnt_r;
  logic [TOTAL_W-1:0] total_r;
  logic [CNT_W-1:0]   n_r;
  out_beat_t          pend_r;

  logic [IDX_W-1:0]   scan_idx_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_vld_r;
  logic [STAMP_W-1:0] rd_stamp_r;
  logic [BYTES_W-1:0] rd_bytes_r;
  logic               found_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic [BYTES_W-1:0] best_bytes_r;

  logic [IDX_W-1:0]   g_idx;
  logic [NUM_GROUPS-1:0] g_mask;
  logic [STAMP_W-1:0] cnt_inc;
  logic               renorm;
  logic [STAMP_W-1:0] new_stamp;
  logic [TOTAL_W:0]   sum_w;
  logic [TOTAL_W-1:0] total_add;
  logic [TOTAL_W:0]   diff_w;
  logic [TOTAL_W-1:0] total_sub;
  logic               hit;
  logic               cand;
  logic [STAMP_W-1:0] cand_stamp;
  logic               do_stamp;
  logic               do_load;
  logic               do_step;
  logic               do_evict;

  assign g_idx    = gid_r[IDX_W-1:0];
  assign g_mask   = NUM_GROUPS'(1) << g_idx;
  assign do_stamp = ctrl.fire && (ctrl.act == ACT_RESTAMP || ctrl.act == ACT_LOAD);
  assign do_load  = ctrl.fire && (ctrl.act == ACT_LOAD);
  assign do_step  = ctrl.fire && (ctrl.act == ACT_SCAN_STEP);
  assign do_evict = ctrl.fire && (ctrl.act == ACT_EVICT);

  // restamp with renormalize at the limit
  always_comb begin
    cnt_inc   = stamp_cnt_r + STAMP_W'(1);
    renorm    = (cnt_inc >= STAMP_LIMIT);
    new_stamp = renorm ? STAMP_W'(1) : cnt_inc;
  end

  // saturating add, clamping subtract
  always_comb begin
    sum_w     = {1'b0, total_r} + {{(TOTAL_W + 1 - BYTES_W){1'b0}}, size_r};
    total_add = sum_w[TOTAL_W] ? TOTAL_MAX : sum_w[TOTAL_W-1:0];
    diff_w    = {1'b0, total_r} - {{(TOTAL_W + 1 - BYTES_W){1'b0}}, best_bytes_r};
    total_sub = diff_w[TOTAL_W] ? '0 : diff_w[TOTAL_W-1:0];
  end

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      if (gid_r == GID_W'(i)) begin
        hit = resident_r[i];
      end
    end
  end

  // candidate from the registered read
  always_comb begin
    cand_stamp = svld_r[rd_idx_r] ? rd_stamp_r : '0;
    cand       = rd_vld_r && resident_r[rd_idx_r] && (rd_idx_r != g_idx) &&
                 (cand_stamp < best_stamp_r);
  end

  always_ff @(posedge clk) begin
    if (do_stamp) begin
      stamp_mem[g_idx] <= new_stamp;
    end
    if (do_load) begin
      bytes_mem[g_idx] <= size_r;
    end
    if (do_step) begin
      rd_stamp_r <= stamp_mem[scan_idx_r];
      rd_bytes_r <= bytes_mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resident_r  <= '0;
      svld_r      <= '0;
      stamp_cnt_r <= '0;
      total_r     <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      n_r         <= '0;
    end else begin
      rd_vld_r <= do_step;
      if (do_stamp) begin
        stamp_cnt_r <= new_stamp;
        // renormalize keeps only the accessed group's stamp
        svld_r      <= renorm ? g_mask : (svld_r | g_mask);
      end
      if (do_load) begin
        total_r           <= total_add;
        resident_r[g_idx] <= (size_r != '0);
        n_r               <= CNT_W'(1);
      end
      if (ctrl.fire && ctrl.act == ACT_SCAN_INIT) begin
        found_r <= 1'b0;
      end else if (cand) begin
        found_r <= 1'b1;
      end
      if (do_evict) begin
        total_r                <= total_sub;
        resident_r[best_idx_r] <= 1'b0;
        svld_r[best_idx_r]     <= 1'b0;
        n_r                    <= n_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire && ctrl.act == ACT_ACCEPT) begin
      gid_r  <= in_beat.group_id;
      size_r <= in_beat.load_size;
    end
    if (ctrl.fire && ctrl.act == ACT_SCAN_INIT) begin
      scan_idx_r <= '0;
    end else if (do_step) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    // best stamp follows every candidate, also while later reads are stepping
    if (ctrl.fire && ctrl.act == ACT_SCAN_INIT) begin
      best_stamp_r <= STAMP_LIMIT;
    end else if (cand) begin
      best_stamp_r <= cand_stamp;
    end
    if (do_step) begin
      rd_idx_r <= scan_idx_r;
    end
    if (cand) begin
      best_idx_r   <= rd_idx_r;
      best_bytes_r <= rd_bytes_r;
    end
    if (ctrl.fire) begin
      case (ctrl.act)
        ACT_LOAD:    pend_r <= '{kind: KIND_MISS, which_group: gid_r,
                                 total_bytes: total_add, last: 1'b0};
        ACT_EVICT:   pend_r <= '{kind: KIND_EVICT,
                                 which_group: GID_W'(best_idx_r),
                                 total_bytes: total_sub, last: 1'b0};
        ACT_SET_REJ: pend_r <= '{kind: KIND_REJECT, which_group: gid_r,
                                 total_bytes: total_r, last: 1'b0};
        ACT_SET_HIT: pend_r <= '{kind: KIND_HIT, which_group: gid_r,
                                 total_bytes: total_r, last: 1'b0};
        default:     pend_r <= pend_r;
      endcase
    end
  end

  always_comb begin
    stat.bad_id    = (gid_r >= GID_W'(NUM_GROUPS));
    stat.hit       = hit;
    stat.no_evict  = (total_r <= budget) || (n_r == CNT_W'(MAX_RESULTS));
    stat.scan_more = (scan_idx_r != IDX_W'(NUM_GROUPS - 1));
    stat.found     = found_r;
    pend           = pend_r;
  end

endmodule

// ===== tb/tb_lru_group_cache_budget_evict_top.sv =====
`timescale 1ns / 1ps
// testbench for lru_group_cache_budget_evict_top: directed and random accesses checked
// against a shadow of the group cache; depends on lrub_pkg and the block's rtl
module tb_lru_group_cache_budget_evict_top;
  import lrub_pkg::*;

  localparam int NG            = NUM_GROUPS_DEF;
  // cycles with no beat on any channel before the run is declared hung; the slowest
  // access (fifteen evictions, each after a full scan of the groups) plus long random stalls
  // stays far below this
  localparam int QUIET_LIMIT   = 5000;
  localparam int ITEMS_PER_SET = 48;
  localparam logic [BYTES_W-1:0] SIZE_MAX = {BYTES_W{1'b1}};

  // shadow of the cache state plus the queue of result beats still owed by the block
  class cache_shadow;
    logic               resident [NUM_GROUPS_DEF];
    logic [BYTES_W-1:0] bytes    [NUM_GROUPS_DEF];
    logic [STAMP_W-1:0] stamp    [NUM_GROUPS_DEF];
    logic [STAMP_W-1:0] stamp_ctr;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] budget;
    out_beat_t          owed_beats [$];
    int errors, accesses, hits, loads, evictions, rejects, budgets;

    function new();
      for (int i = 0; i < NUM_GROUPS_DEF; i++) begin
        resident[i] = 1'b0;
        bytes[i]    = '0;
        stamp[i]    = '0;
      end
      stamp_ctr = '0;
      total     = '0;
      budget    = BUDGET_RESET;
      errors = 0; accesses = 0; hits = 0; loads = 0; evictions = 0; rejects = 0;
      budgets = 0;
    endfunction

    function void set_budget(logic [TOTAL_W-1:0] value);
      budget = value;
      budgets++;
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    function void owe(logic [KIND_W-1:0] kind, logic [GID_W-1:0] grp);
      out_beat_t r;
      r.kind        = kind;
      r.which_group = grp;
      r.total_bytes = total;
      r.last        = 1'b0;
      owed_beats.insert(owed_beats.size(), r);
    endfunction

    // restamp a group; on reaching the limit all other stamps are cleared
    function void restamp(int g);
      stamp_ctr = stamp_ctr + 1'b1;
      stamp[g]  = stamp_ctr;
      if (stamp[g] >= STAMP_LIMIT) begin
        for (int i = 0; i < NUM_GROUPS_DEF; i++)
          if (i != g) stamp[i] = '0;
        stamp_ctr = STAMP_W'(1);
        stamp[g]  = STAMP_W'(1);
      end
    endfunction

    function void note_access(in_beat_t b);
      int                 g;
      int                 n;
      int                 best;
      bit                 found;
      logic [STAMP_W-1:0] best_stamp;
      out_beat_t          tail;
      accesses++;
      if (b.group_id >= NUM_GROUPS_DEF) begin
        owe(KIND_REJECT, b.group_id);
        rejects++;
      end else begin
        g = int'(b.group_id);
        restamp(g);
        if (resident[g]) begin
          owe(KIND_HIT, b.group_id);
          hits++;
        end else begin
          bytes[g] = b.load_size;
          restamp(g);
          if ({4'b0, b.load_size} > TOTAL_MAX - total) total = TOTAL_MAX;
          else total = total + TOTAL_W'(b.load_size);
          resident[g] = (b.load_size != 0);
          owe(KIND_MISS, b.group_id);
          loads++;
          n = 1;
          while (total > budget && n < MAX_RESULTS) begin
            found      = 1'b0;
            best       = 0;
            best_stamp = STAMP_LIMIT;
            for (int i = 0; i < NUM_GROUPS_DEF; i++) begin
              if (i == g || !resident[i] || bytes[i] == 0) continue;
              if (stamp[i] < best_stamp) begin
                best_stamp = stamp[i];
                best       = i;
                found      = 1'b1;
              end
            end
            if (!found) break;
            if ({4'b0, bytes[best]} > total) total = '0;
            else total = total - TOTAL_W'(bytes[best]);
            bytes[best]    = '0;
            stamp[best]    = '0;
            resident[best] = 1'b0;
            owe(KIND_EVICT, best[GID_W-1:0]);
            evictions++;
            n++;
          end
        end
      end
      tail      = owed_beats[owed_beats.size() - 1];
      tail.last = 1'b1;
      owed_beats[owed_beats.size() - 1] = tail;
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (owed_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d group %0d total %0d last %0d",
               got.kind, got.which_group, got.total_bytes, got.last);
        errors++;
        return;
      end
      want = owed_beats.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.which_group !== want.which_group) begin
        $error("which_group: expected %0d, actual %0d", want.which_group, got.which_group);
        errors++;
      end
      if (got.total_bytes !== want.total_bytes) begin
        $error("total_bytes: expected %0d, actual %0d", want.total_bytes, got.total_bytes);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_beat_t           in_beat;
  logic               out_valid;
  logic               out_ready;
  out_beat_t          out_beat;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [TOTAL_W-1:0] cfg_data;

  // percentages for sender gaps and receiver stalls, changed per phase
  int in_idle_pct;
  int out_stall_pct;
  int quiet_cycles;

  cache_shadow shadow;

  lru_group_cache_budget_evict_top #(.NUM_GROUPS(NG)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: ready is redrawn at every falling edge from the current stall rate
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // result monitor: every accepted out beat is checked against the oldest owed beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      shadow.check_result(out_beat);
    end
  end

  // watchdog: counts cycles in which no channel moves a beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("lru_group_cache_budget_evict_top test failed");
        $finish;
      end
    end
  end

  // one access beat; valid holds with the payload until the block takes it,
  // and the shadow predicts the results at the accepting edge
  task automatic send_access(input logic [GID_W-1:0] gid, input logic [BYTES_W-1:0] size);
    in_beat_t b;
    b.group_id  = gid;
    b.load_size = size;
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!in_ready);
    shadow.note_access(b);
  endtask

  // sender pause: drop valid and hold off until every owed beat has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // budget writes happen only with the block drained
  task automatic write_budget(input logic [TOTAL_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_budget(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sizes mostly scaled to the budget so evictions are frequent, with zero,
  // full-width random and all-ones sizes mixed in
  function automatic logic [BYTES_W-1:0] pick_size(input logic [TOTAL_W-1:0] budget);
    logic [63:0]        r;
    logic [63:0]        lim;
    logic [BYTES_W-1:0] size;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0, 1:    size = '0;
      2, 3:    size = r[BYTES_W-1:0];
      4:       size = SIZE_MAX;
      default: begin
        lim = {24'b0, budget} / 3 + 1;
        if (lim > {28'b0, SIZE_MAX}) lim = {28'b0, SIZE_MAX};
        size = BYTES_W'(r % (lim + 1));
      end
    endcase
    return size;
  endfunction

  // group ids: mostly in range, a few rejected ones up to the field maximum
  function automatic logic [GID_W-1:0] pick_group();
    logic [GID_W-1:0] gid;
    case ($urandom_range(0, 19))
      0:       gid = GID_W'($urandom_range(NG, 255));
      1:       gid = {GID_W{1'b1}};
      default: gid = GID_W'($urandom_range(0, NG - 1));
    endcase
    return gid;
  endfunction

  // budget settings for the random sets: tiny, small, power of two, full random
  function automatic logic [TOTAL_W-1:0] pick_budget(input int flavor);
    logic [TOTAL_W-1:0] value;
    case (flavor)
      0:       value = TOTAL_W'($urandom_range(100, 4000));
      1:       value = TOTAL_W'({$urandom, $urandom});
      2:       value = TOTAL_W'(1) << $urandom_range(20, 38);
      default: value = TOTAL_W'($urandom_range(0, 50));
    endcase
    return value;
  endfunction

  initial begin
    int gap_pct  [4];
    int stall_pct[4];
    shadow        = new();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_beat       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    // idling phases: none, sender gaps, receiver stalls, light on both
    gap_pct   = '{0, 54, 0, 10};
    stall_pct = '{0, 0, 54, 10};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset budget of 4 GiB ----
    // rejected ids at the bottom and top of the out-of-range span
    send_access(GID_W'(NG), SIZE_MAX);
    send_access({GID_W{1'b1}}, '0);
    // zero-size load stays non-resident, so the next access misses again
    send_access(GID_W'(0), '0);
    send_access(GID_W'(0), BYTES_W'(5));
    send_access(GID_W'(1), BYTES_W'(1) << 31);
    // goes five bytes over budget: group 0 is evicted and the total lands on the budget
    send_access(GID_W'(2), BYTES_W'(1) << 31);
    // hit refreshes group 1, then a 4 GiB load evicts group 2 before group 1
    send_access(GID_W'(1), SIZE_MAX);
    send_access(GID_W'(3), BYTES_W'(1) << 32);

    // zero budget: everything but the loaded group goes, and eviction stops
    // over budget once no candidate is left
    write_budget('0);
    send_access(GID_W'(4), BYTES_W'(1));
    send_access(GID_W'(4), BYTES_W'(1));
    send_access(GID_W'(5), SIZE_MAX);

    // full budget: fill fifteen groups with the largest size
    write_budget(TOTAL_MAX);
    for (int g = 0; g < NG - 1; g++) begin
      send_access(GID_W'(g), SIZE_MAX);
    end
    // budget of one byte: the next load evicts all fifteen in stamp order,
    // giving the longest result burst
    write_budget(TOTAL_W'(1));
    send_access(GID_W'(NG - 1), BYTES_W'(1));

    // ---- random part: four idling phases, two budget settings each ----
    for (int p = 0; p < 4; p++) begin
      in_idle_pct   = gap_pct[p];
      out_stall_pct = stall_pct[p];
      for (int s = 0; s < 2; s++) begin
        write_budget(pick_budget((2 * p + s) % 4));
        for (int k = 0; k < ITEMS_PER_SET; k++) begin
          // now and then the sender holds off until the block has drained
          if ($urandom_range(0, 29) == 0) wait_drained();
          send_access(pick_group(), pick_size(shadow.budget));
        end
      end
    end

    // let every owed beat come back, then watch a little longer for strays
    in_idle_pct   = 0;
    out_stall_pct = 0;
    wait_drained();
    repeat (40) @(posedge clk);

    $display("covered %0d accesses over %0d budget settings and four idling phases",
             shadow.accesses, shadow.budgets);
    $display("  %0d hits, %0d loads, %0d evictions, %0d rejected ids, %0d mismatches",
             shadow.hits, shadow.loads, shadow.evictions, shadow.rejects, shadow.errors);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("lru_group_cache_budget_evict_top test passed");
    end else begin
      $display("lru_group_cache_budget_evict_top test failed");
    end
    $finish;
  end

endmodule
